@@ rtl/mexp_pkg.sv @@
// Package for the modular exponentiation block.
// Register map, configuration struct and unit status struct; no dependencies.

package mexp_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned ADDR_W = 3;

	typedef enum logic {
		REG_MODULUS  = 1'b0,
		REG_EXPONENT = 1'b1
	} reg_idx_t;

	localparam logic [DATA_W-1:0] MODULUS_RST  = 32'd3233;
	localparam logic [DATA_W-1:0] EXPONENT_RST = 32'd17;

	typedef struct packed {
		logic [DATA_W-1:0] modulus;
		logic [DATA_W-1:0] exponent;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mm_status_t;

endpackage

@@ rtl/modular_exponentiation.sv @@
// Top level of the modular exponentiation block: right-to-left square and
// multiply sequencer around one shared serial modular multiplier.
// Depends on mexp_pkg, mexp_regs and mexp_modmul.
//
//   channel   direction  handshake                 payload
//   base      in         base_valid / base_stall   base_value   [31:0]
//   result    out        result_valid / result_stall power_result [31:0]
//   config    in         APB psel/penable/pwrite   paddr [2:0], pwdata/prdata [31:0]
//
// An item costs one base reduction, at most WIDTH multiplies and WIDTH - 1
// squares in the serial multiplier, each followed by a pass through S_LOOP.
// base_stall stays high from acceptance until the result enters the output
// register; a stalled result holds there while the next item is accepted.
// Reset loads modulus 3233 and exponent 17 and empties the output register.

module modular_exponentiation #(
	parameter int unsigned WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mexp_pkg::ADDR_W-1:0]   paddr,
	input  logic [mexp_pkg::DATA_W-1:0]   pwdata,
	output logic [mexp_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          base_valid,
	output logic                          base_stall,
	input  logic [mexp_pkg::DATA_W-1:0]   base_value,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [mexp_pkg::DATA_W-1:0]   power_result
);
	import mexp_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RED,
		S_LOOP,
		S_MUL,
		S_SQR,
		S_FINISH
	} state_t;

	cfg_t             cfg;
	mm_status_t       mm_st;
	logic [WIDTH-1:0] mm_prod;

	state_t           state_q;
	logic [WIDTH-1:0] mod_q;
	logic [WIDTH-1:0] exp_q;
	logic [WIDTH-1:0] base_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] res_q;
	logic [WIDTH-1:0] op_a_q;
	logic [WIDTH-1:0] op_c_q;
	logic             start_q;
	logic             out_valid_q;
	logic [DATA_W-1:0] out_data_q;

	logic [WIDTH-1:0] m_in;
	logic [WIDTH-1:0] one_mod;
	logic             accept;

	mexp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mexp_modmul #(
		.WIDTH (WIDTH)
	) u_modmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_q),
		.mplier  (op_a_q),
		.mcand   (op_c_q),
		.modulus (mod_q),
		.product (mm_prod),
		.status  (mm_st)
	);

	assign m_in       = cfg.modulus[WIDTH-1:0];
	assign one_mod    = (m_in == WIDTH'(1)) ? '0 : WIDTH'(1);
	assign base_stall = (state_q != S_IDLE);
	assign accept     = base_valid & ~base_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (out_valid_q && !result_stall && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						mod_q <= m_in;
						exp_q <= cfg.exponent[WIDTH-1:0];
						acc_q <= WIDTH'(1);
						if (m_in == '0) begin
							res_q   <= '0;
							state_q <= S_FINISH;
						end else begin
							op_a_q  <= base_value[WIDTH-1:0];
							op_c_q  <= one_mod;
							start_q <= 1'b1;
							state_q <= S_RED;
						end
					end
				end
				S_RED: begin
					if (mm_st.done) begin
						base_q  <= mm_prod;
						state_q <= S_LOOP;
					end
				end
				S_LOOP: begin
					if (exp_q == '0) begin
						res_q   <= acc_q;
						state_q <= S_FINISH;
					end else if (exp_q[0]) begin
						op_a_q  <= acc_q;
						op_c_q  <= base_q;
						start_q <= 1'b1;
						state_q <= S_MUL;
					end else begin
						op_a_q  <= base_q;
						op_c_q  <= base_q;
						start_q <= 1'b1;
						state_q <= S_SQR;
					end
				end
				S_MUL: begin
					if (mm_st.done) begin
						acc_q    <= mm_prod;
						exp_q[0] <= 1'b0;
						state_q  <= S_LOOP;
					end
				end
				S_SQR: begin
					if (mm_st.done) begin
						base_q  <= mm_prod;
						exp_q   <= exp_q >> 1;
						state_q <= S_LOOP;
					end
				end
				S_FINISH: begin
					if (!out_valid_q || !result_stall) begin
						out_valid_q <= 1'b1;
						out_data_q  <= DATA_W'(res_q);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign power_result = out_data_q;

endmodule

@@ rtl/mexp_regs.sv @@
// Configuration registers of the modular exponentiation block, APB-style port.
// Depends on mexp_pkg.

module mexp_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mexp_pkg::ADDR_W-1:0]   paddr,
	input  logic [mexp_pkg::DATA_W-1:0]   pwdata,
	output logic [mexp_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output mexp_pkg::cfg_t                cfg
);
	import mexp_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[2]);
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.modulus  <= MODULUS_RST;
			cfg_q.exponent <= EXPONENT_RST;
		end else if (wr_en) begin
			case (idx)
				REG_MODULUS:  cfg_q.modulus  <= pwdata;
				REG_EXPONENT: cfg_q.exponent <= pwdata;
				default:      cfg_q.modulus  <= cfg_q.modulus;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MODULUS:  prdata = cfg_q.modulus;
			REG_EXPONENT: prdata = cfg_q.exponent;
			default:      prdata = '0;
		endcase
	end

endmodule

@@ rtl/mexp_modmul.sv @@
// Bit-serial modular multiplier: one multiplier bit per cycle, double and add
// with two conditional subtractions. Multiplicand must be below the modulus.
// Depends on mexp_pkg.

module mexp_modmul #(
	parameter int unsigned WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [WIDTH-1:0]         mplier,
	input  logic [WIDTH-1:0]         mcand,
	input  logic [WIDTH-1:0]         modulus,
	output logic [WIDTH-1:0]         product,
	output mexp_pkg::mm_status_t     status
);
	import mexp_pkg::*;

	localparam int unsigned CNT_W = $clog2(WIDTH);

	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] c_q;
	logic [WIDTH-1:0] r_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [WIDTH:0]   dbl;
	logic [WIDTH-1:0] dbl_red;
	logic [WIDTH-1:0] addend;
	logic [WIDTH:0]   sum;
	logic [WIDTH-1:0] sum_red;

	always_comb begin
		dbl     = {r_q, 1'b0};
		dbl_red = (dbl >= {1'b0, modulus}) ? WIDTH'(dbl - {1'b0, modulus}) : dbl[WIDTH-1:0];
		addend  = a_q[WIDTH-1] ? c_q : '0;
		sum     = {1'b0, dbl_red} + {1'b0, addend};
		sum_red = (sum >= {1'b0, modulus}) ? WIDTH'(sum - {1'b0, modulus}) : sum[WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= mplier;
			c_q <= mcand;
			r_q <= '0;
		end else if (busy_q) begin
			a_q <= {a_q[WIDTH-2:0], 1'b0};
			r_q <= sum_red;
		end
	end

	assign product     = r_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

@@ dv/modular_exponentiation_checker.sv @@
// Checker for the modular exponentiation block: follows register writes on the
// APB port, predicts base ** exponent mod modulus for each accepted base and
// compares every accepted result in order. Depends on mexp_pkg.

module modular_exponentiation_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic                          pready,
	input  logic [mexp_pkg::ADDR_W-1:0]   paddr,
	input  logic [mexp_pkg::DATA_W-1:0]   pwdata,
	input  logic                          base_valid,
	input  logic                          base_stall,
	input  logic [mexp_pkg::DATA_W-1:0]   base_value,
	input  logic                          result_valid,
	input  logic                          result_stall,
	input  logic [mexp_pkg::DATA_W-1:0]   power_result,
	output int unsigned                   mismatches,
	output int unsigned                   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [mexp_pkg::DATA_W-1:0] modulus_cfg;
	logic [mexp_pkg::DATA_W-1:0] exponent_cfg;
	logic [mexp_pkg::DATA_W-1:0] expected_powers[$];
	logic [mexp_pkg::DATA_W-1:0] want;
	int unsigned                 fail_total;

	function automatic logic [31:0] modpow(input logic [31:0] base, input logic [31:0] expo,
			input logic [31:0] modu);
		logic [63:0] acc;
		logic [63:0] sq;
		logic [63:0] m;
		logic [31:0] e;
		if (modu == 32'd0)
			return 32'd0;
		m = {32'd0, modu};
		sq = {32'd0, base} % m;
		acc = 64'd1;
		e = expo;
		while (e != 32'd0) begin
			if (e[0])
				acc = (acc * sq) % m;
			e = e >> 1;
			sq = (sq * sq) % m;
		end
		return acc[31:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_cfg = mexp_pkg::MODULUS_RST;
			exponent_cfg = mexp_pkg::EXPONENT_RST;
			expected_powers.delete();
			fail_total = 0;
		end else begin
			if (base_valid && !base_stall)
				expected_powers.push_back(modpow(base_value, exponent_cfg, modulus_cfg));
			if (result_valid && !result_stall) begin
				if (expected_powers.size() == 0) begin
					fail_total++;
					if (fail_total <= 10)
						$display("unexpected power_result %h with no base pending", power_result);
				end else begin
					want = expected_powers.pop_front();
					if (power_result !== want) begin
						fail_total++;
						if (fail_total <= 10)
							$display("power_result mismatch: expected %h, got %h", want,
								power_result);
					end
				end
			end
			if (psel && penable && pwrite && pready)
				case (mexp_pkg::reg_idx_t'(paddr[2]))
				mexp_pkg::REG_MODULUS:  modulus_cfg = pwdata;
				mexp_pkg::REG_EXPONENT: exponent_cfg = pwdata;
				default: ;
				endcase
		end
		mismatches <= fail_total;
		outstanding <= expected_powers.size();
	end

endmodule

@@ dv/modular_exponentiation_tb.sv @@
// Top of the modular exponentiation testbench: clock, reset, APB register
// writes, base stimulus and result back-pressure, watchdog and verdict.
// Depends on mexp_pkg, modular_exponentiation and modular_exponentiation_checker.

module modular_exponentiation_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mexp_pkg::*;

	localparam int unsigned QUIET_LIMIT = 20000;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                base_valid;
	logic                base_stall;
	logic [DATA_W-1:0]   base_value;
	logic                result_valid;
	logic                result_stall;
	logic [DATA_W-1:0]   power_result;
	int unsigned         mismatches;
	int unsigned         outstanding;
	int unsigned         quiet_cycles;
	int unsigned         bases_sent;
	int unsigned         settings_done;
	int unsigned         drains_done;
	bit                  no_idle;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	modular_exponentiation #(.WIDTH(32)) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.base_valid   (base_valid),
		.base_stall   (base_stall),
		.base_value   (base_value),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.power_result (power_result)
	);

	modular_exponentiation_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.base_valid   (base_valid),
		.base_stall   (base_stall),
		.base_value   (base_value),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.power_result (power_result),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	task automatic send_base(input logic [31:0] value);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			base_valid <= 1'b0;
			if ($urandom_range(0, 1) == 1)
				do @(posedge clk); while (base_stall);
			repeat (gap) @(posedge clk);
		end
		base_valid <= 1'b1;
		base_value <= value;
		do @(posedge clk); while (base_stall);
		bases_sent++;
	endtask

	task automatic drain;
		base_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic apply_setting(input logic [31:0] mod_val, input logic [31:0] exp_val);
		drain();
		repeat (4) @(posedge clk);
		write_reg(REG_MODULUS, mod_val);
		write_reg(REG_EXPONENT, exp_val);
		psel <= 1'b0;
		penable <= 1'b0;
		settings_done++;
	endtask

	function automatic logic [31:0] pick_base(input logic [31:0] mod_val);
		case ($urandom_range(0, 9))
		0:       return 32'd0;
		1:       return 32'd1;
		2:       return mod_val - 32'd1;
		3:       return mod_val;
		4:       return mod_val + 32'd1;
		5:       return 32'hFFFF_FFFF;
		default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_modulus();
		case ($urandom_range(0, 5))
		0:       return $urandom_range(2, 255);
		1:       return $urandom_range(256, 65535);
		2:       return $urandom | 32'h8000_0000;
		3:       return 32'd1;
		default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_exponent();
		case ($urandom_range(0, 5))
		0:       return $urandom_range(0, 15);
		1:       return $urandom_range(0, 1023);
		2:       return 32'd65537;
		3:       return 32'hFFFF_FFFF;
		default: return $urandom;
		endcase
	endfunction

	always @(posedge clk) begin
		if (!arst_n || (base_valid && !base_stall) || (result_valid && !result_stall)
				|| (psel && penable))
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: %0d cycles without progress, %0d results pending",
				quiet_cycles, outstanding);
			$display("modular_exponentiation_tb: FAIL");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		int unsigned gap;
		result_stall <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, 3);
			if (gap != 0)
				result_stall <= 1'b1;
			do @(posedge clk); while (!result_valid);
			if (gap != 0) begin
				repeat (gap - 1) @(posedge clk);
				result_stall <= 1'b0;
				do @(posedge clk); while (!(result_valid && !result_stall));
			end
		end
	end

	initial begin
		logic [31:0] mod_val;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		base_valid <= 1'b0;
		base_value <= '0;
		no_idle = 1'b0;
		bases_sent = 0;
		settings_done = 0;
		drains_done = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values of modulus and exponent
		send_base(32'd0);
		send_base(32'd1);
		send_base(32'd65);
		send_base(32'd3232);
		send_base(32'd3233);
		send_base(32'd3234);
		send_base(32'hFFFF_FFFF);
		send_base(32'h8000_0000);

		// modulus one with and without a zero exponent, modulus zero
		apply_setting(32'd1, 32'd0);
		send_base(32'd0);
		send_base(32'd5);
		send_base(32'hFFFF_FFFF);
		apply_setting(32'd1, 32'd7);
		send_base(32'd9);
		apply_setting(32'd0, 32'd5);
		send_base(32'd7);
		send_base(32'hFFFF_FFFF);

		// widest modulus and exponent, zero exponent on a large prime, top-bit modulus with exponent one
		apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_base(32'hFFFF_FFFE);
		send_base(32'hFFFF_FFFF);
		send_base(32'd2);
		apply_setting(32'hFFFF_FFFB, 32'd0);
		send_base(32'd12345);
		send_base(32'd0);
		apply_setting(32'h8000_0000, 32'd1);
		send_base(32'h8000_0001);
		send_base(32'h7FFF_FFFF);

		for (int phase = 0; phase < 10; phase++) begin
			mod_val = pick_modulus();
			apply_setting(mod_val, pick_exponent());
			no_idle = (phase % 3 == 0);
			for (int n = 0; n < 26; n++) begin
				if ($urandom_range(0, 24) == 0) begin
					drain();
					drains_done++;
				end
				send_base(pick_base(mod_val));
			end
		end

		drain();
		repeat (50) @(posedge clk);
		$display("run covered %0d bases over %0d register settings plus reset values,",
			bases_sent, settings_done);
		$display("moduli 0, 1 and all-ones included, random idling and %0d full drains",
			drains_done);
		if (mismatches == 0 && outstanding == 0)
			$display("modular_exponentiation_tb: PASS");
		else
			$display("modular_exponentiation_tb: FAIL");
		$finish;
	end

endmodule
